// ===== rtl/clf_pkg.sv =====
// shared types and constants of the clamped lorentz factor block
package clf_pkg;

    localparam int OUT_FRAC_BITS_DEF = 16;
    localparam int QUEUE_DEPTH       = 4;
    localparam int ITER_STAGES       = 32;
    localparam int ACC_W             = 128;
    localparam int D_W               = 63;
    localparam logic [30:0] LIMIT_RESET = 31'd2147268900;

    typedef struct packed {
        logic signed [31:0] beta;
        logic               last_in;
    } t_in;

    typedef struct packed {
        logic [31:0] gamma;
        logic        clamped;
        logic        saturated;
        logic        last_out;
    } t_out;

    typedef struct packed {
        logic [D_W-1:0] d;
        logic           clamped;
        logic           saturated;
        logic           last;
    } t_work;

endpackage

// ===== rtl/clf_front.sv =====
// front part: clamp, square, form one minus beta squared and flag saturation
module clf_front #(
    parameter int OUT_FRAC_BITS = clf_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [30:0]    i_limit,
    input  logic           i_valid,
    output logic           o_stall,
    input  clf_pkg::t_in   i_in,
    output logic           o_valid,
    input  logic           i_ready,
    output clf_pkg::t_work o_work
);
    import clf_pkg::*;

    localparam logic [D_W-1:0] ONE_Q62 = D_W'(1) << 62;
    localparam logic [D_W-1:0] SAT_TH  = D_W'(1) << (2 * OUT_FRAC_BITS - 2);

    logic              front_en;
    logic              is_over;
    logic signed [31:0] n_b;
    logic [31:0]       mag;

    logic               r_v1, r_v2, r_v3;
    logic signed [31:0] r_b1;
    logic               r_c1, r_c2, r_c3;
    logic               r_l1, r_l2, r_l3;
    logic [63:0]        r_sq2;
    logic [D_W-1:0]     r_d3;
    logic               r_s3;

    assign front_en = !r_v3 || i_ready;
    assign o_stall  = !front_en;

    assign is_over = i_in.beta > $signed({1'b0, i_limit});
    assign n_b     = is_over ? $signed({1'b0, i_limit}) : i_in.beta;
    assign mag     = r_b1[31] ? 32'(-r_b1) : 32'(r_b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (front_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (front_en) begin
            r_b1  <= n_b;
            r_c1  <= is_over;
            r_l1  <= i_in.last_in;
            r_sq2 <= mag * mag;
            r_c2  <= r_c1;
            r_l2  <= r_l1;
            // square is at most 2^62, so the difference never wraps
            r_d3  <= ONE_Q62 - {1'b0, r_sq2[61:0]} - {r_sq2[62], 62'd0};
            r_s3  <= (ONE_Q62 - D_W'(r_sq2)) <= SAT_TH;
            r_c3  <= r_c2;
            r_l3  <= r_l2;
        end
    end

    assign o_valid           = r_v3;
    assign o_work.d          = r_d3;
    assign o_work.clamped    = r_c3;
    assign o_work.saturated  = r_s3;
    assign o_work.last       = r_l3;

endmodule

// ===== rtl/clf_queue.sv =====
// short queue between the front and back parts
module clf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  clf_pkg::t_work i_data,
    output logic           o_ready,
    input  logic           i_pop,
    output logic           o_valid,
    output clf_pkg::t_work o_data
);
    import clf_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_work           r_mem [0:QUEUE_DEPTH-1];
    logic [PW-1:0]   r_wp, r_rp;
    logic [PW:0]     r_cnt;
    logic            do_push, do_pop;

    assign o_ready = r_cnt != (PW+1)'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= PW'(r_wp + 1'b1);
            if (do_pop)  r_rp <= PW'(r_rp + 1'b1);
            if (do_push && !do_pop)      r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end

endmodule

// ===== rtl/clf_back.sv =====
// back part: bit-serial pipelined inverse square root, one result bit per stage
module clf_back #(
    parameter int OUT_FRAC_BITS = clf_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_pop,
    input  clf_pkg::t_work i_work,
    output logic           o_valid,
    input  logic           i_stall,
    output clf_pkg::t_out  o_out
);
    import clf_pkg::*;

    localparam logic [ACC_W-1:0] TARGET = ACC_W'(1) << (2 * OUT_FRAC_BITS + 62);

    logic             back_en;
    logic             r_v [0:ITER_STAGES];
    logic [31:0]      r_g [0:ITER_STAGES];
    logic [ACC_W-1:0] r_p [0:ITER_STAGES];
    logic [ACC_W-1:0] r_q [0:ITER_STAGES];
    logic [D_W-1:0]   r_d [0:ITER_STAGES];
    logic             r_c [0:ITER_STAGES];
    logic             r_s [0:ITER_STAGES];
    logic             r_l [0:ITER_STAGES];

    assign back_en = !(r_v[ITER_STAGES] && i_stall);
    assign o_pop   = back_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (back_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (back_en) begin
            r_g[0] <= '0;
            r_p[0] <= '0;
            r_q[0] <= '0;
            r_d[0] <= i_work.d;
            r_c[0] <= i_work.clamped;
            r_s[0] <= i_work.saturated;
            r_l[0] <= i_work.last;
        end
    end

    for (genvar s = 0; s < ITER_STAGES; s++) begin : g_stage
        localparam int K = ITER_STAGES - 1 - s;
        logic [ACC_W-1:0] d_ext;
        logic [ACC_W-1:0] cand;
        logic             fit;

        // (g + 2^k)^2 d = g^2 d + 2^(k+1) g d + 2^(2k) d
        assign d_ext = ACC_W'(r_d[s]);
        assign cand  = r_p[s] + (r_q[s] << (K + 1)) + (d_ext << (2 * K));
        assign fit   = cand <= TARGET;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (back_en) begin
                r_v[s+1] <= r_v[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (back_en) begin
                r_g[s+1] <= r_g[s] | (32'(fit) << K);
                r_p[s+1] <= fit ? cand : r_p[s];
                r_q[s+1] <= fit ? r_q[s] + (d_ext << K) : r_q[s];
                r_d[s+1] <= r_d[s];
                r_c[s+1] <= r_c[s];
                r_s[s+1] <= r_s[s];
                r_l[s+1] <= r_l[s];
            end
        end
    end

    assign o_valid         = r_v[ITER_STAGES];
    assign o_out.gamma     = r_s[ITER_STAGES] ? '1 : r_g[ITER_STAGES];
    assign o_out.clamped   = r_c[ITER_STAGES];
    assign o_out.saturated = r_s[ITER_STAGES];
    assign o_out.last_out  = r_l[ITER_STAGES];

endmodule

// ===== rtl/clamped_lorentz_factor_core.sv =====
// top level of the clamped lorentz factor block
// result path when nothing stalls: 3 front registers, 1 queue entry, back input register
//   and 32 root stages in line
// throughput: one transaction per cycle while neither side stalls; every part is fully pipelined
// reset: synchronous active low, empties all stages and the queue, limit back to 0.9999
module clamped_lorentz_factor_core #(
    parameter int OUT_FRAC_BITS = clf_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // limit register write
    input  logic          i_cfg_we,
    input  logic [30:0]   i_cfg_wdata,
    // input transactions
    input  logic          i_valid,
    output logic          o_stall,
    input  clf_pkg::t_in  i_in,
    // result transactions
    output logic          o_valid,
    input  logic          i_stall,
    output clf_pkg::t_out o_out
);
    import clf_pkg::*;

    logic [30:0] r_limit;
    logic        f_valid, q_ready;
    t_work       f_work;
    logic        q_valid, b_pop;
    t_work       q_work;

    // clamp limit, Q0.31
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    // front: clamp beta, square it, form d = 1 - beta^2 and flag saturation
    clf_front #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_limit (r_limit),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_in    (i_in),
        .o_valid (f_valid),
        .i_ready (q_ready),
        .o_work  (f_work)
    );

    // decoupling queue so either side can stall alone
    clf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  (f_work),
        .o_ready (q_ready),
        .i_pop   (b_pop),
        .o_valid (q_valid),
        .o_data  (q_work)
    );

    // back: restoring search for largest g with g^2 d <= 2^(2F+62), last stage is output reg
    clf_back #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_pop   (b_pop),
        .i_work  (q_work),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_out   (o_out)
    );

endmodule

// ===== sim/clamped_lorentz_factor_core_tb.sv =====
// testbench of the clamped lorentz factor block: directed and random betas against a local model
module clamped_lorentz_factor_core_tb;
    import clf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS = OUT_FRAC_BITS_DEF;
    // leave some margin after the pipeline drains before touching the limit or ending
    localparam int SETTLE_CYCLES = 48;
    localparam logic [30:0] LIMIT_TOP = 31'h7FFF_FFFF;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [30:0] i_cfg_wdata = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    t_in         i_in = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    t_out        o_out;

    // limit as the block should currently hold it
    logic [30:0] limit_now = LIMIT_RESET;
    // gamma results still on their way through the pipeline
    t_out        gamma_pending[$];
    int          mismatches = 0;
    // no idling on either side when set
    bit          quiet = 1'b0;
    int          stall_left = 0;

    clamped_lorentz_factor_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_in       (i_in),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out      (o_out)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // expected result for one beta under a given limit
    function automatic t_out lorentz_gamma(logic signed [31:0] beta, logic last,
                                           logic [30:0] lim);
        logic signed [32:0] b;
        logic [32:0]        mag;
        logic [63:0]        d;
        logic [127:0]       prod;
        logic [32:0]        lo;
        logic [32:0]        hi;
        logic [32:0]        mid;
        t_out               r;
        b = 33'(beta);
        r = '0;
        r.last_out = last;
        // only the positive side is ever clamped
        if (b > $signed({2'b00, lim})) begin
            b = $signed({2'b00, lim});
            r.clamped = 1'b1;
        end
        mag = (b < 0) ? -b : b;
        // one minus beta squared, exact, Q2.62
        d = (64'd1 << 62) - {31'd0, mag} * {31'd0, mag};
        if (d <= (64'd1 << (2 * FRAC_BITS - 2))) begin
            r.gamma = 32'hFFFF_FFFF;
            r.saturated = 1'b1;
        end else begin
            // largest g with g*g*d <= 2^(2F+62)
            lo = '0;
            hi = 33'h0_FFFF_FFFF;
            while (lo < hi) begin
                mid = lo + (hi - lo + 1) / 2;
                prod = {95'd0, mid} * {95'd0, mid} * {64'd0, d};
                if (prod <= (128'd1 << (2 * FRAC_BITS + 62))) begin
                    lo = mid;
                end else begin
                    hi = mid - 1;
                end
            end
            r.gamma = lo[31:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        mismatches++;
    endtask

    // result side: random stall bursts, none once quiet
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (!quiet && i_rst_n && $urandom_range(0, 7) == 0) begin
            i_stall <= 1'b1;
            stall_left <= $urandom_range(0, 6);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // compare every accepted result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (gamma_pending.size() == 0) begin
                report_mismatch("unexpected transaction gamma", o_out.gamma, '0);
            end else begin
                want = gamma_pending.pop_front();
                if (o_out.gamma !== want.gamma)
                    report_mismatch("gamma", o_out.gamma, want.gamma);
                if (o_out.clamped !== want.clamped)
                    report_mismatch("clamped", 32'(o_out.clamped), 32'(want.clamped));
                if (o_out.saturated !== want.saturated)
                    report_mismatch("saturated", 32'(o_out.saturated), 32'(want.saturated));
                if (o_out.last_out !== want.last_out)
                    report_mismatch("last_out", 32'(o_out.last_out), 32'(want.last_out));
            end
        end
    end

    // send one beta; valid stays high into the next call when there is no gap
    task automatic send_beta(logic signed [31:0] beta, logic last);
        int gap;
        gap = (!quiet && $urandom_range(0, 7) == 0) ? $urandom_range(1, 7) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in.beta <= beta;
        i_in.last_in <= last;
        do @(posedge i_clk); while (o_stall);
        gamma_pending.push_back(lorentz_gamma(beta, last, limit_now));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (gamma_pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // limit is only changed with the pipeline empty
    task automatic write_limit(logic [30:0] value);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        limit_now = value;
    endtask

    // beta spread over the interesting regions: both ends, around zero, around the limit, full range
    function automatic logic signed [31:0] random_beta();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000 + $urandom_range(0, 4095);
            1: return 32'sh7FFF_FFFF - $urandom_range(0, 4095);
            2: return $signed($urandom_range(0, 8191)) - 4096;
            3: return $signed({1'b0, limit_now}) + $signed($urandom_range(0, 64)) - 32;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        // extremes, zero, minus and plus one, betas right at the reset limit, halves and bit patterns
        send_beta(32'sh8000_0000, 1'b0);
        send_beta(32'sh8000_0001, 1'b1);
        send_beta(32'sh7FFF_FFFF, 1'b0);
        send_beta(32'sh0000_0000, 1'b1);
        send_beta(-32'sd1, 1'b0);
        send_beta(32'sd1, 1'b0);
        send_beta($signed({1'b0, LIMIT_RESET}), 1'b0);
        send_beta($signed({1'b0, LIMIT_RESET}) + 1, 1'b1);
        send_beta(-$signed({1'b0, LIMIT_RESET}), 1'b0);
        send_beta(32'sh4000_0000, 1'b0);
        send_beta(32'shC000_0000, 1'b1);
        send_beta(32'sh5555_5555, 1'b0);
        send_beta(32'shAAAA_AAAA, 1'b1);
    endtask

    task automatic test_limit_extremes();
        // limit zero clamps every positive beta
        write_limit('0);
        send_beta(32'sd1, 1'b0);
        send_beta(32'sh7FFF_FFFF, 1'b0);
        send_beta(32'sd0, 1'b1);
        send_beta(32'sh8000_0000, 1'b0);
        // full-scale limit clamps nothing
        write_limit(LIMIT_TOP);
        send_beta(32'sh7FFF_FFFF, 1'b1);
        send_beta(32'sh7FFF_FFFE, 1'b0);
        send_beta(32'sh8000_0000, 1'b1);
        write_limit(31'h2AAA_AAAA);
        send_beta(32'sh2AAA_AAAB, 1'b0);
        send_beta(32'sh2AAA_AAAA, 1'b1);
    endtask

    task automatic test_random(int count);
        repeat (count) send_beta(random_beta(), $urandom_range(0, 3) == 0);
    endtask

    task automatic test_random_limits();
        write_limit(LIMIT_RESET);
        test_random(400);
        write_limit(31'($urandom));
        test_random(400);
        // sender holds off until the pipeline has emptied, then carries on
        wait_drained();
        test_random(200);
        write_limit(LIMIT_TOP);
        test_random(300);
    endtask

    task automatic test_quiet_tail();
        write_limit(31'(31'h7FFF_0000 + $urandom_range(0, 65535)));
        quiet = 1'b1;
        test_random(300);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_limit_extremes();
        test_random_limits();
        test_quiet_tail();
        wait_drained();
        if (mismatches == 0 && gamma_pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // watchdog well beyond the slowest legal run
    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end
endmodule
